// ===== hdl/miller_rabin_prime_test_defines.svh =====
// Assertion macros used by miller_rabin_prime_test.sv.
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MRPT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MRPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/mrpt_pkg.sv =====
package mrpt_pkg;

    localparam int NUM_WIDTH_DEFAULT = 32;
    localparam int CAND_WIDTH        = 32;
    localparam int OUT_TDATA_WIDTH   = 8;
    localparam int BASE_WIDTH        = 50;
    localparam int NUM_BASES         = 3;

    localparam logic [BASE_WIDTH-1:0] WITNESS_BASE [NUM_BASES] = '{
        50'd15,
        50'd7363882082,
        50'd992620450144556
    };

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ===== hdl/mrpt_modmul.sv =====
module mrpt_modmul #(
    parameter int NUM_WIDTH = mrpt_pkg::NUM_WIDTH_DEFAULT,
    parameter int MB_WIDTH  = mrpt_pkg::BASE_WIDTH,
    localparam int CW       = $clog2(MB_WIDTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_WIDTH-1:0]  op_a,
    input  logic [MB_WIDTH-1:0]   op_b,
    input  logic [CW-1:0]         nbits,
    input  logic [NUM_WIDTH-1:0]  modulus,
    output mrpt_pkg::mm_status_t  status,
    output logic [NUM_WIDTH-1:0]  result
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0] r_reg, r_next;
    logic [NUM_WIDTH-1:0] a_reg, a_next;
    logic [MB_WIDTH-1:0]  b_reg, b_next;

    logic [NUM_WIDTH+1:0] sum;
    logic [NUM_WIDTH+1:0] n_ext;
    logic [NUM_WIDTH+1:0] n2_ext;
    logic [NUM_WIDTH+1:0] red;

    // One multiplier bit per cycle, MSB first: r = (2r + bit * a) mod n.
    always_comb
    begin
        n_ext  = {2'b00, modulus};
        n2_ext = {1'b0, modulus, 1'b0};
        sum    = {1'b0, r_reg, 1'b0}
                 + {2'b00, (b_reg[MB_WIDTH-1] ? a_reg : {NUM_WIDTH{1'b0}})};
        if (sum >= n2_ext)
        begin
            red = sum - n2_ext;
        end
        else if (sum >= n_ext)
        begin
            red = sum - n_ext;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            r_next    = '0;
            a_next    = op_a;
            b_next    = op_b;
        end
        else if (busy_reg)
        begin
            r_next   = red[NUM_WIDTH-1:0];
            b_next   = {b_reg[MB_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = r_reg;

endmodule

// ===== hdl/miller_rabin_prime_test.sv =====
// Deterministic Miller-Rabin primality test of the low NUM_WIDTH bits of each
// 32-bit request, using the three bases 15, 7363882082 and 992620450144556.
// The answer is one byte whose bit 0 is 1 for a prime and 0 otherwise; 0 and 1
// are not prime. The block handles one request at a time and drops s_tready
// from acceptance until the verdict is moved to the output register, which may
// still be waiting for the downstream side. Zero, one, two and even numbers
// are decided in the check state alone. Odd numbers go through a single
// bit-serial modular multiplier. Each base costs one 50-bit reduction, a
// left-to-right power with up to two products per bit of the odd part of
// n - 1, and one product per trailing zero of n - 1; the bits of the odd part
// and the trailing zeros together number at most NUM_WIDTH. Composites
// usually stop after the first base.
`include "miller_rabin_prime_test_defines.svh"

module miller_rabin_prime_test #(
    parameter int NUM_WIDTH = mrpt_pkg::NUM_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: candidate[31:0].
    input  logic [mrpt_pkg::CAND_WIDTH-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: prime_flag[0], zero fill [7:1].
    output logic [mrpt_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata
);

    localparam int MB_WIDTH = mrpt_pkg::BASE_WIDTH;
    localparam int CW       = $clog2(MB_WIDTH + 1);
    localparam int BW       = $clog2(NUM_WIDTH);
    localparam int KW       = $clog2(mrpt_pkg::NUM_BASES + 1);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_CHECK     = 13'b0000000000010,
        ST_SPLIT     = 13'b0000000000100,
        ST_NEXT_BASE = 13'b0000000001000,
        ST_RED_WAIT  = 13'b0000000010000,
        ST_POW_STEP  = 13'b0000000100000,
        ST_SQ_WAIT   = 13'b0000001000000,
        ST_POW_MUL   = 13'b0000010000000,
        ST_MUL_WAIT  = 13'b0000100000000,
        ST_POW_NEXT  = 13'b0001000000000,
        ST_CHK_STEP  = 13'b0010000000000,
        ST_CHK_WAIT  = 13'b0100000000000,
        ST_DONE      = 13'b1000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_flag_reg, out_flag_next;
    logic                 verdict_reg, verdict_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] u_reg, u_next;
    logic [NUM_WIDTH-1:0] x_reg, x_next;
    logic [NUM_WIDTH-1:0] a_reg, a_next;
    logic [BW-1:0]        s_reg, s_next;
    logic [BW-1:0]        i_reg, i_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic [KW-1:0]        base_idx_reg, base_idx_next;

    logic                 mm_start;
    logic [NUM_WIDTH-1:0] mm_a;
    logic [MB_WIDTH-1:0]  mm_b;
    logic [CW-1:0]        mm_nbits;
    mrpt_pkg::mm_status_t mm_status;
    logic [NUM_WIDTH-1:0] mm_result;
    logic [NUM_WIDTH-1:0] n_minus_one;
    logic [NUM_WIDTH-1:0] one;

    assign one         = NUM_WIDTH'(1);
    assign n_minus_one = n_reg - one;

    mrpt_modmul #(
        .NUM_WIDTH (NUM_WIDTH),
        .MB_WIDTH  (MB_WIDTH)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .nbits   (mm_nbits),
        .modulus (n_reg),
        .status  (mm_status),
        .result  (mm_result)
    );

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_flag_next = out_flag_reg;
        verdict_next  = verdict_reg;
        n_next        = n_reg;
        u_next        = u_reg;
        x_next        = x_reg;
        a_next        = a_reg;
        s_next        = s_reg;
        i_next        = i_reg;
        bit_next      = bit_reg;
        base_idx_next = base_idx_reg;
        mm_start      = 1'b0;
        mm_a          = '0;
        mm_b          = '0;
        mm_nbits      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next     = s_tdata[NUM_WIDTH-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (n_reg[NUM_WIDTH-1:1] == '0)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else if (n_reg == NUM_WIDTH'(2))
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    u_next     = n_minus_one;
                    s_next     = '0;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (!u_reg[0])
                begin
                    u_next = {1'b0, u_reg[NUM_WIDTH-1:1]};
                    s_next = s_reg + BW'(1);
                end
                else
                begin
                    base_idx_next = '0;
                    state_next    = ST_NEXT_BASE;
                end
            end
            ST_NEXT_BASE:
            begin
                if (base_idx_reg == KW'(mrpt_pkg::NUM_BASES))
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_a       = one;
                    mm_b       = mrpt_pkg::WITNESS_BASE[base_idx_reg];
                    mm_nbits   = CW'(mrpt_pkg::BASE_WIDTH);
                    state_next = ST_RED_WAIT;
                end
            end
            ST_RED_WAIT:
            begin
                if (mm_status.done)
                begin
                    if (mm_result == '0)
                    begin
                        base_idx_next = base_idx_reg + KW'(1);
                        state_next    = ST_NEXT_BASE;
                    end
                    else
                    begin
                        a_next     = mm_result;
                        x_next     = one;
                        bit_next   = BW'(NUM_WIDTH - 1);
                        state_next = ST_POW_STEP;
                    end
                end
            end
            ST_POW_STEP:
            begin
                if (x_reg != one)
                begin
                    mm_start   = 1'b1;
                    mm_a       = x_reg;
                    mm_b       = {x_reg, {(MB_WIDTH - NUM_WIDTH){1'b0}}};
                    mm_nbits   = CW'(NUM_WIDTH);
                    state_next = ST_SQ_WAIT;
                end
                else
                begin
                    state_next = ST_POW_MUL;
                end
            end
            ST_SQ_WAIT:
            begin
                if (mm_status.done)
                begin
                    x_next     = mm_result;
                    state_next = ST_POW_MUL;
                end
            end
            ST_POW_MUL:
            begin
                if (u_reg[bit_reg])
                begin
                    if (x_reg == one)
                    begin
                        x_next     = a_reg;
                        state_next = ST_POW_NEXT;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        mm_a       = a_reg;
                        mm_b       = {x_reg, {(MB_WIDTH - NUM_WIDTH){1'b0}}};
                        mm_nbits   = CW'(NUM_WIDTH);
                        state_next = ST_MUL_WAIT;
                    end
                end
                else
                begin
                    state_next = ST_POW_NEXT;
                end
            end
            ST_MUL_WAIT:
            begin
                if (mm_status.done)
                begin
                    x_next     = mm_result;
                    state_next = ST_POW_NEXT;
                end
            end
            ST_POW_NEXT:
            begin
                if (bit_reg == '0)
                begin
                    i_next     = s_reg;
                    state_next = ST_CHK_STEP;
                end
                else
                begin
                    bit_next   = bit_reg - BW'(1);
                    state_next = ST_POW_STEP;
                end
            end
            ST_CHK_STEP:
            begin
                if (x_reg == one)
                begin
                    base_idx_next = base_idx_reg + KW'(1);
                    state_next    = ST_NEXT_BASE;
                end
                else if (i_reg == '0)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_a       = x_reg;
                    mm_b       = {x_reg, {(MB_WIDTH - NUM_WIDTH){1'b0}}};
                    mm_nbits   = CW'(NUM_WIDTH);
                    state_next = ST_CHK_WAIT;
                end
            end
            ST_CHK_WAIT:
            begin
                if (mm_status.done)
                begin
                    if (mm_result == one && x_reg != n_minus_one)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        x_next     = mm_result;
                        i_next     = i_reg - BW'(1);
                        state_next = ST_CHK_STEP;
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_flag_next = verdict_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flag_reg <= out_flag_next;
        verdict_reg  <= verdict_next;
        n_reg        <= n_next;
        u_reg        <= u_next;
        x_reg        <= x_next;
        a_reg        <= a_next;
        s_reg        <= s_next;
        i_reg        <= i_next;
        bit_reg      <= bit_next;
        base_idx_reg <= base_idx_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mrpt_pkg::OUT_TDATA_WIDTH - 1){1'b0}}, out_flag_reg};

    `MRPT_ASSERT_IMPLIES(a_start_idle_unit, mm_start, !mm_status.busy)
    `MRPT_ASSERT_IMPLIES(a_done_when_waiting, mm_status.done,
        state_reg == ST_RED_WAIT || state_reg == ST_SQ_WAIT ||
        state_reg == ST_MUL_WAIT || state_reg == ST_CHK_WAIT)
    `MRPT_ASSERT_NEXT(a_accept_to_check, s_tvalid && s_tready, state_reg == ST_CHECK)
    `MRPT_ASSERT_IMPLIES(a_prime_odd_or_two, state_reg == ST_DONE && verdict_reg,
        n_reg == NUM_WIDTH'(2) || n_reg[0])

endmodule
